/* rtl/bpa_pkg.sv */
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, constants and region mapping functions of the page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int PAGES     = 16384;
    localparam int REGIONS   = 4;
    localparam int WORD_BITS = 32;
    localparam int WORDS     = (PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW   = $clog2(WORDS);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int IDX_W     = $clog2(PAGES);
    localparam int CNT_W     = 15;
    localparam int FRAME_W   = 20;
    localparam int CUM_W     = CNT_W + 2;
    localparam int CFG_W     = 20;
    localparam int CFG_AW    = 3;

    localparam logic [CNT_W-1:0]   COUNT_MAX   = 15'h7FFF;
    localparam logic [CNT_W-1:0]   COUNT_RESET = 15'd16384;
    localparam logic [FRAME_W-1:0] BASE0_RESET = 20'd256;
    localparam logic [CNT_W-1:0]   PAGES0_RESET = 15'd16384;

    typedef enum logic [1:0] {
        REQ_ALLOC_ONE = 2'd0,
        REQ_ALLOC_RUN = 2'd1,
        REQ_FREE      = 2'd2,
        REQ_QUERY     = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_ZERO_CNT  = 2'd2,
        ST_UNUSED    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_BIT,
        S_CLR_RD,
        S_CLR_WR,
        S_FREE_CALC,
        S_FREE_RD,
        S_FREE_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [REGIONS-1:0][FRAME_W-1:0] base;
        logic [REGIONS-1:0][CNT_W-1:0]   pages;
    } regions_t;

    // region 0 only, all other regions absent
    localparam regions_t REGIONS_RESET = {{((REGIONS-1)*FRAME_W){1'b0}}, BASE0_RESET,
                                          {((REGIONS-1)*CNT_W){1'b0}}, PAGES0_RESET};

    typedef struct packed {
        logic                 re;
        logic                 we;
        logic [WORD_AW-1:0]   addr;
        logic [WORD_BITS-1:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic             hit;
        logic [CUM_W-1:0] idx;
    } idx_hit_t;

    function automatic logic [CNT_W:0] mapped_span(input regions_t rg);
        logic [CUM_W-1:0] sum;
        sum = '0;
        for (int r = 0; r < REGIONS; r++)
            sum = sum + CUM_W'(rg.pages[r]);
        if (sum > CUM_W'(PAGES))
            sum = CUM_W'(PAGES);
        return sum[CNT_W:0];
    endfunction

    function automatic logic [FRAME_W-1:0] idx_to_frame(input regions_t rg,
                                                        input logic [IDX_W-1:0] idx);
        logic [CUM_W-1:0]   cum;
        logic [CUM_W-1:0]   ix;
        logic [CUM_W-1:0]   off;
        logic [FRAME_W-1:0] f;
        logic               found;
        cum   = '0;
        ix    = CUM_W'(idx);
        f     = '0;
        found = 1'b0;
        off   = '0;
        for (int r = 0; r < REGIONS; r++) begin
            if (!found && ix >= cum && ix < cum + CUM_W'(rg.pages[r])) begin
                off   = ix - cum;
                f     = rg.base[r] + FRAME_W'(off);
                found = 1'b1;
            end
            cum = cum + CUM_W'(rg.pages[r]);
        end
        return f;
    endfunction

    function automatic idx_hit_t frame_to_idx(input regions_t rg,
                                              input logic [FRAME_W-1:0] frame);
        logic [CUM_W-1:0]   cum;
        logic [FRAME_W:0]   lim;
        idx_hit_t           res;
        cum = '0;
        res = '0;
        for (int r = 0; r < REGIONS; r++) begin
            lim = {1'b0, rg.base[r]} + (FRAME_W+1)'(rg.pages[r]);
            if (!res.hit && frame >= rg.base[r] && {1'b0, frame} < lim) begin
                res.hit = 1'b1;
                res.idx = cum + CUM_W'(frame - rg.base[r]);
            end
            cum = cum + CUM_W'(rg.pages[r]);
        end
        return res;
    endfunction

endpackage

/* rtl/bpa_regs.sv */
// ----------------------------------------------------------------------------
// bpa_regs
// Region configuration registers: base frame and page count of each region.
// ----------------------------------------------------------------------------
module bpa_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [bpa_pkg::CFG_AW-1:0] cfg_index,
    input  logic [bpa_pkg::CFG_W-1:0]  cfg_data,
    output bpa_pkg::regions_t          regions
);

    bpa_pkg::regions_t regions_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regions_reg <= bpa_pkg::REGIONS_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index[0] == 1'b0)
                regions_reg.base[cfg_index[bpa_pkg::CFG_AW-1:1]] <=
                    cfg_data[bpa_pkg::FRAME_W-1:0];
            else
                regions_reg.pages[cfg_index[bpa_pkg::CFG_AW-1:1]] <=
                    cfg_data[bpa_pkg::CNT_W-1:0];
        end
    end

    assign regions = regions_reg;

endmodule

/* rtl/bpa_mem.sv */
// ----------------------------------------------------------------------------
// bpa_mem
// Free bitmap storage, one word per access, registered read data.
// ----------------------------------------------------------------------------
module bpa_mem (
    input  logic                          clk,
    input  bpa_pkg::mem_req_t             req,
    output logic [bpa_pkg::WORD_BITS-1:0] rdata
);

    logic [bpa_pkg::WORD_BITS-1:0] mem [bpa_pkg::WORDS];
    logic [bpa_pkg::WORD_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
            mem[req.addr] <= req.wdata;
        if (req.re)
            rdata_reg <= mem[req.addr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bpa_ctrl.sv */
// ----------------------------------------------------------------------------
// bpa_ctrl
// Request sequencer: bitmap init sweep, bit-serial run scan, word-wise clear
// of an allocated run, and page-by-page free.
// ----------------------------------------------------------------------------
module bpa_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bpa_pkg::regions_t             regions,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    req_type,
    input  logic [bpa_pkg::CNT_W-1:0]     page_count,
    input  logic [31:0]                   byte_address,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [bpa_pkg::FRAME_W-1:0]   start_frame,
    output logic [bpa_pkg::CNT_W-1:0]     avail_count,
    output bpa_pkg::mem_req_t             mem_req,
    input  logic [bpa_pkg::WORD_BITS-1:0] mem_rdata
);

    localparam int IW = bpa_pkg::IDX_W;
    localparam int CW = bpa_pkg::CNT_W;
    localparam int FW = bpa_pkg::FRAME_W;
    localparam int AW = bpa_pkg::WORD_AW;
    localparam int BW = bpa_pkg::BIT_W;
    localparam int WB = bpa_pkg::WORD_BITS;

    bpa_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   init_reg, init_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   scan_reg, scan_next;
    logic [CW-1:0]   run_reg, run_next;
    logic [IW-1:0]   start_reg, start_next;
    logic [IW-1:0]   last_reg, last_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [AW-1:0]   cw_reg, cw_next;
    logic [FW-1:0]   fr_reg, fr_next;
    logic [CW-1:0]   fc_reg, fc_next;
    logic [1:0]      status_reg, status_next;
    logic [FW-1:0]   frame_reg, frame_next;

    logic [CW:0]         total;
    logic [IW-1:0]       cand;
    logic [CW-1:0]       run_inc;
    logic [FW-1:0]       cand_frame;
    bpa_pkg::idx_hit_t   fhit;
    logic [BW-1:0]       lo_bit, hi_bit;
    logic [WB-1:0]       clr_mask;

    assign total      = bpa_pkg::mapped_span(regions);
    assign cand       = (run_reg == '0) ? scan_reg[IW-1:0] : start_reg;
    assign run_inc    = run_reg + CW'(1);
    assign cand_frame = bpa_pkg::idx_to_frame(regions, cand);
    assign fhit       = bpa_pkg::frame_to_idx(regions, fr_reg);
    assign lo_bit     = (cw_reg == start_reg[IW-1:BW]) ? start_reg[BW-1:0] : '0;
    assign hi_bit     = (cw_reg == last_reg[IW-1:BW]) ? last_reg[BW-1:0] : '1;
    assign clr_mask   = ({WB{1'b1}} << lo_bit) & ({WB{1'b1}} >> (BW'(WB - 1) - hi_bit));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bpa_pkg::S_INIT;
            init_reg   <= '0;
            fc_reg     <= bpa_pkg::COUNT_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            init_reg   <= init_next;
            fc_reg     <= fc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        scan_reg   <= scan_next;
        run_reg    <= run_next;
        start_reg  <= start_next;
        last_reg   <= last_next;
        idx_reg    <= idx_next;
        cw_reg     <= cw_next;
        fr_reg     <= fr_next;
        status_reg <= status_next;
        frame_reg  <= frame_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        init_next   = init_reg;
        cnt_next    = cnt_reg;
        scan_next   = scan_reg;
        run_next    = run_reg;
        start_next  = start_reg;
        last_next   = last_reg;
        idx_next    = idx_reg;
        cw_next     = cw_reg;
        fr_next     = fr_reg;
        fc_next     = fc_reg;
        status_next = status_reg;
        frame_next  = frame_reg;
        mem_req     = '0;
        in_ready    = 1'b0;
        out_valid   = 1'b0;

        unique case (state_reg)
            bpa_pkg::S_INIT:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = init_reg;
                mem_req.wdata = '1;
                init_next     = init_reg + AW'(1);
                if (init_reg == AW'(bpa_pkg::WORDS - 1))
                    state_next = bpa_pkg::S_IDLE;
            end
            bpa_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    status_next = bpa_pkg::ST_DONE;
                    frame_next  = '0;
                    scan_next   = '0;
                    run_next    = '0;
                    fr_next     = byte_address[31:12];
                    cnt_next    = page_count;
                    unique case (bpa_pkg::req_t'(req_type))
                        bpa_pkg::REQ_ALLOC_ONE:
                        begin
                            cnt_next   = CW'(1);
                            state_next = bpa_pkg::S_SCAN_RD;
                        end
                        bpa_pkg::REQ_ALLOC_RUN:
                        begin
                            if (page_count == '0)
                            begin
                                status_next = bpa_pkg::ST_ZERO_CNT;
                                state_next  = bpa_pkg::S_DONE;
                            end
                            else
                                state_next = bpa_pkg::S_SCAN_RD;
                        end
                        bpa_pkg::REQ_FREE:
                        begin
                            if (page_count == '0 || byte_address[11:0] != '0)
                                state_next = bpa_pkg::S_DONE;
                            else
                                state_next = bpa_pkg::S_FREE_CALC;
                        end
                        bpa_pkg::REQ_QUERY:
                            state_next = bpa_pkg::S_DONE;
                        default:
                            state_next = bpa_pkg::S_DONE;
                    endcase
                end
            end
            bpa_pkg::S_SCAN_RD:
            begin
                if ({1'b0, scan_reg} >= total)
                begin
                    status_next = bpa_pkg::ST_NO_SPACE;
                    state_next  = bpa_pkg::S_DONE;
                end
                else
                begin
                    mem_req.re   = 1'b1;
                    mem_req.addr = scan_reg[IW-1:BW];
                    state_next   = bpa_pkg::S_SCAN_BIT;
                end
            end
            bpa_pkg::S_SCAN_BIT:
            begin
                if ({1'b0, scan_reg} >= total)
                begin
                    status_next = bpa_pkg::ST_NO_SPACE;
                    state_next  = bpa_pkg::S_DONE;
                end
                else
                begin
                    scan_next = scan_reg + CW'(1);
                    if (scan_reg[BW-1:0] == '1)
                        state_next = bpa_pkg::S_SCAN_RD;
                    if (!mem_rdata[scan_reg[BW-1:0]])
                        run_next = '0;
                    else if (run_inc == cnt_reg)
                    begin
                        if (cand_frame == '0)
                            run_next = '0;
                        else
                        begin
                            frame_next = cand_frame;
                            start_next = cand;
                            last_next  = scan_reg[IW-1:0];
                            cw_next    = cand[IW-1:BW];
                            state_next = bpa_pkg::S_CLR_RD;
                        end
                    end
                    else
                    begin
                        run_next   = run_inc;
                        start_next = cand;
                    end
                end
            end
            bpa_pkg::S_CLR_RD:
            begin
                mem_req.re   = 1'b1;
                mem_req.addr = cw_reg;
                state_next   = bpa_pkg::S_CLR_WR;
            end
            bpa_pkg::S_CLR_WR:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = cw_reg;
                mem_req.wdata = mem_rdata & ~clr_mask;
                cw_next       = cw_reg + AW'(1);
                if (cw_reg == last_reg[IW-1:BW])
                begin
                    fc_next    = (fc_reg > cnt_reg) ? fc_reg - cnt_reg : '0;
                    state_next = bpa_pkg::S_DONE;
                end
                else
                    state_next = bpa_pkg::S_CLR_RD;
            end
            bpa_pkg::S_FREE_CALC:
            begin
                if (fhit.hit && fhit.idx < (bpa_pkg::CUM_W)'(total))
                begin
                    idx_next   = fhit.idx[IW-1:0];
                    state_next = bpa_pkg::S_FREE_RD;
                end
                else
                begin
                    fr_next  = fr_reg + FW'(1);
                    cnt_next = cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                        state_next = bpa_pkg::S_DONE;
                end
            end
            bpa_pkg::S_FREE_RD:
            begin
                mem_req.re   = 1'b1;
                mem_req.addr = idx_reg[IW-1:BW];
                state_next   = bpa_pkg::S_FREE_WR;
            end
            bpa_pkg::S_FREE_WR:
            begin
                if (!mem_rdata[idx_reg[BW-1:0]])
                begin
                    mem_req.we    = 1'b1;
                    mem_req.addr  = idx_reg[IW-1:BW];
                    mem_req.wdata = mem_rdata | (WB'(1) << idx_reg[BW-1:0]);
                    if (fc_reg != bpa_pkg::COUNT_MAX)
                        fc_next = fc_reg + CW'(1);
                end
                fr_next  = fr_reg + FW'(1);
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    state_next = bpa_pkg::S_DONE;
                else
                    state_next = bpa_pkg::S_FREE_CALC;
            end
            bpa_pkg::S_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = bpa_pkg::S_IDLE;
            end
            default:
                state_next = bpa_pkg::S_IDLE;
        endcase
    end

    assign status      = status_reg;
    assign start_frame = frame_reg;
    assign avail_count = fc_reg;

endmodule

/* rtl/bitmap_page_allocator_core.sv */
// ----------------------------------------------------------------------------
// bitmap_page_allocator_core
// Page frame allocator over a free bitmap held in a 512 x 32 memory.
// ----------------------------------------------------------------------------
// After reset the block sweeps the bitmap to all free, one word a cycle, and
// accepts no beat until the sweep ends (configuration writes are taken). One
// request is handled at a time. Allocations scan the bitmap one index per
// cycle, pausing to read each word before its bits are scanned, then clear the
// run found word by word with a read and a write of each word. A free looks up
// each address in the regions and, for a mapped page, reads its word and sets
// its bit if clear. Query and rejected requests go straight to the result beat,
// which stays valid until taken; the next request is accepted after that.
module bitmap_page_allocator_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [bpa_pkg::CFG_AW-1:0]   cfg_index,
    input  logic [bpa_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   req_type,
    input  logic [bpa_pkg::CNT_W-1:0]    page_count,
    input  logic [31:0]                  byte_address,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   status,
    output logic [bpa_pkg::FRAME_W-1:0]  start_frame,
    output logic [bpa_pkg::CNT_W-1:0]    avail_count
);

    bpa_pkg::regions_t             regions;
    bpa_pkg::mem_req_t             mem_req;
    logic [bpa_pkg::WORD_BITS-1:0] mem_rdata;

    bpa_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regions   (regions)
    );

    bpa_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    bpa_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .regions      (regions),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .page_count   (page_count),
        .byte_address (byte_address),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .start_frame  (start_frame),
        .avail_count  (avail_count),
        .mem_req      (mem_req),
        .mem_rdata    (mem_rdata)
    );

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bitmap_page_allocator_core: a bit-level free map
// model predicts every result beat, directed tests cover region edges and
// frame wrap, random phases run small region maps under idle and stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int FW      = bpa_pkg::FRAME_W;
    localparam int CW      = bpa_pkg::CNT_W;
    localparam int GW      = bpa_pkg::CFG_W;
    localparam int AW      = bpa_pkg::CFG_AW;
    localparam int NREG    = bpa_pkg::REGIONS;

    typedef enum logic [2:0] {
        CFG_BASE0, CFG_PAGES0, CFG_BASE1, CFG_PAGES1,
        CFG_BASE2, CFG_PAGES2, CFG_BASE3, CFG_PAGES3
    } cfg_reg_t;

    typedef struct packed {
        bpa_pkg::status_t st;
        logic [FW-1:0]    frame;
        logic [CW-1:0]    cnt;
    } alloc_beat_t;

    localparam int WATCHDOG = 200000;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [AW-1:0]     cfg_index;
    logic [GW-1:0]     cfg_data;
    logic              in_valid;
    logic              in_ready;
    bpa_pkg::req_t     req_type;
    logic [CW-1:0]     page_count;
    logic [31:0]       byte_address;
    logic              out_valid;
    logic              out_ready;
    logic [1:0]        status;
    logic [FW-1:0]     start_frame;
    logic [CW-1:0]     avail_count;

    bitmap_page_allocator_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .page_count(page_count), .byte_address(byte_address),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .start_frame(start_frame), .avail_count(avail_count)
    );

    // free map model
    bit          page_free [bpa_pkg::PAGES];
    int unsigned free_total;
    int unsigned rg_base [NREG];
    int unsigned rg_pages [NREG];

    alloc_beat_t pending_beats [$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_req;
    int          hold_left;
    int          quiet_cycles;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned map_size();
        int unsigned sum;
        sum = 0;
        for (int r = 0; r < NREG; r++)
            sum += rg_pages[r];
        return (sum > bpa_pkg::PAGES) ? bpa_pkg::PAGES : sum;
    endfunction

    function automatic int unsigned frame_of(int unsigned idx);
        int unsigned cum;
        cum = 0;
        for (int r = 0; r < NREG; r++) begin
            if (idx >= cum && idx < cum + rg_pages[r])
                return (rg_base[r] + idx - cum) & 32'hFFFFF;
            cum += rg_pages[r];
        end
        return 0;
    endfunction

    function automatic void release_page(logic [31:0] addr, int unsigned span);
        int unsigned cum;
        int unsigned frame;
        int unsigned idx;
        cum = 0;
        if (addr[11:0] != 0)
            return;
        frame = addr >> 12;
        for (int r = 0; r < NREG; r++) begin
            if (frame >= rg_base[r] && frame < rg_base[r] + rg_pages[r]) begin
                idx = cum + frame - rg_base[r];
                if (idx >= span)
                    return;
                if (!page_free[idx]) begin
                    page_free[idx] = 1'b1;
                    if (free_total < bpa_pkg::COUNT_MAX)
                        free_total++;
                end
                return;
            end
            cum += rg_pages[r];
        end
    endfunction

    function automatic alloc_beat_t serve_request(bpa_pkg::req_t req, int unsigned cnt,
                                                  logic [31:0] addr);
        alloc_beat_t b;
        int unsigned span;
        int unsigned run;
        int unsigned first;
        int unsigned f;
        span = map_size();
        b.st = bpa_pkg::ST_DONE;
        b.frame = '0;
        case (req)
            bpa_pkg::REQ_ALLOC_ONE: begin
                b.st = bpa_pkg::ST_NO_SPACE;
                for (int unsigned i = 0; i < span; i++) begin
                    if (page_free[i] && frame_of(i) != 0) begin
                        page_free[i] = 1'b0;
                        if (free_total > 0)
                            free_total--;
                        b.st = bpa_pkg::ST_DONE;
                        b.frame = FW'(frame_of(i));
                        break;
                    end
                end
            end
            bpa_pkg::REQ_ALLOC_RUN: begin
                if (cnt == 0) begin
                    b.st = bpa_pkg::ST_ZERO_CNT;
                end else begin
                    b.st = bpa_pkg::ST_NO_SPACE;
                    run = 0;
                    first = 0;
                    for (int unsigned i = 0; i < span; i++) begin
                        if (!page_free[i]) begin
                            run = 0;
                            continue;
                        end
                        run++;
                        if (run == 1)
                            first = i;
                        if (run == cnt) begin
                            f = frame_of(first);
                            if (f == 0) begin
                                run = 0;
                                continue;
                            end
                            for (int unsigned j = 0; j < cnt; j++)
                                page_free[first + j] = 1'b0;
                            free_total = (free_total > cnt) ? free_total - cnt : 0;
                            b.st = bpa_pkg::ST_DONE;
                            b.frame = FW'(f);
                            break;
                        end
                    end
                end
            end
            bpa_pkg::REQ_FREE: begin
                for (int unsigned i = 0; i < cnt; i++)
                    release_page(addr + (i << 12), span);
            end
            default: ;
        endcase
        b.cnt = CW'(free_total);
        return b;
    endfunction

    task automatic send_request(bpa_pkg::req_t req, int unsigned cnt, logic [31:0] addr);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= req;
        page_count   <= CW'(cnt);
        byte_address <= addr;
        do @(posedge clk); while (!in_ready);
        pending_beats.push_back(serve_request(req, cnt & 32'h7FFF, addr));
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        wait (pending_beats.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_regions(int unsigned b[NREG], int unsigned p[NREG]);
        for (int r = 0; r < NREG; r++) begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_reg_t'(CFG_BASE0 + 2 * r);
            cfg_data  <= GW'(b[r]);
            @(posedge clk);
            cfg_index <= cfg_reg_t'(CFG_PAGES0 + 2 * r);
            cfg_data  <= GW'(p[r]);
            @(posedge clk);
            rg_base[r]  = b[r] & 32'hFFFFF;
            rg_pages[r] = p[r] & 32'h7FFF;
        end
        cfg_we <= 1'b0;
    endtask

    task automatic random_regions();
        int unsigned b[NREG];
        int unsigned p[NREG];
        for (int r = 0; r < NREG; r++) begin
            p[r] = $urandom_range(0, 64);
            case ($urandom_range(9))
                0, 1: b[r] = 0;
                2:    b[r] = 32'hFFFFF - $urandom_range(0, 8);
                3, 4: b[r] = (r > 0) ? (b[r-1] + $urandom_range(0, 8)) & 32'hFFFFF : 1;
                default: b[r] = $urandom & 32'hFFFFF;
            endcase
        end
        set_regions(b, p);
    endtask

    task automatic random_request();
        int unsigned sel;
        int unsigned r;
        logic [31:0] addr;
        sel = $urandom_range(99);
        if (sel < 30) begin
            send_request(bpa_pkg::REQ_ALLOC_ONE, $urandom & 32'h7FFF, $urandom);
        end else if (sel < 60) begin
            send_request(bpa_pkg::REQ_ALLOC_RUN,
                         ($urandom_range(9) == 0) ? $urandom_range(0, map_size() + 2)
                                                  : $urandom_range(0, 12),
                         $urandom);
        end else if (sel < 90) begin
            r = $urandom_range(0, NREG - 1);
            addr = (((rg_base[r] + $urandom_range(0, rg_pages[r] + 1)) & 32'hFFFFF) << 12);
            sel = $urandom_range(99);
            if (sel < 10)
                addr = addr + $urandom_range(1, 4095);
            else if (sel < 25)
                addr = $urandom;
            send_request(bpa_pkg::REQ_FREE,
                         ($urandom_range(9) == 0) ? $urandom_range(0, 80)
                                                  : $urandom_range(0, 10),
                         addr);
        end else begin
            send_request(bpa_pkg::REQ_QUERY, $urandom & 32'h7FFF, $urandom);
        end
    endtask

    task automatic test_reset_map();
        send_request(bpa_pkg::REQ_QUERY, 0, 0);
        send_request(bpa_pkg::REQ_ALLOC_ONE, 0, 0);
        send_request(bpa_pkg::REQ_ALLOC_RUN, 0, 0);
        send_request(bpa_pkg::REQ_ALLOC_RUN, 3, 32'hFFFFFFFF);
        send_request(bpa_pkg::REQ_FREE, 1, 32'h0010_0800);
        send_request(bpa_pkg::REQ_FREE, 1, 32'h0010_0000);
        send_request(bpa_pkg::REQ_FREE, 1, 32'h0010_0000);
        send_request(bpa_pkg::REQ_FREE, 0, 32'h0010_1000);
        send_request(bpa_pkg::REQ_FREE, 1, 32'h0000_0000);
        send_request(bpa_pkg::REQ_ALLOC_RUN, 16384, 0);
        send_request(bpa_pkg::REQ_FREE, 2, 32'hFFFF_F000);
        send_request(bpa_pkg::REQ_FREE, 16384, 32'h0010_0000);
        send_request(bpa_pkg::REQ_QUERY, 32'h7FFF, 32'hFFFF_FFFF);
        wait_drain();
    endtask

    task automatic test_frame_edges();
        int unsigned b[NREG] = '{0, 32'hFFFFF, 2, 32'h80000};
        int unsigned p[NREG] = '{8, 4, 4, 16384};
        set_regions(b, p);
        send_request(bpa_pkg::REQ_ALLOC_ONE, 0, 0);
        send_request(bpa_pkg::REQ_ALLOC_RUN, 3, 0);
        send_request(bpa_pkg::REQ_ALLOC_RUN, 6, 0);
        send_request(bpa_pkg::REQ_ALLOC_ONE, 0, 0);
        send_request(bpa_pkg::REQ_FREE, 1, 32'h0000_3000);
        send_request(bpa_pkg::REQ_FREE, 4, 32'hFFFF_E000);
        send_request(bpa_pkg::REQ_FREE, 2, 32'h83FF_8000);
        send_request(bpa_pkg::REQ_FREE, 2, 32'h8000_0000);
        send_request(bpa_pkg::REQ_QUERY, 0, 0);
        wait_drain();
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, bit squeeze);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int blk = 0; blk < 4; blk++) begin
            random_regions();
            if (squeeze && blk == 1)
                hold_req = 300;
            for (int n = 0; n < 52; n++)
                random_request();
            wait_drain();
        end
    endtask

    always @(posedge clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        alloc_beat_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: st %0d frame %h cnt %0d",
                             status, start_frame, avail_count);
            end else begin
                want = pending_beats.pop_front();
                if (status !== want.st || start_frame !== want.frame
                    || avail_count !== want.cnt) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat mismatch: exp st %0d frame %h cnt %0d, got %0d %h %0d",
                                 want.st, want.frame, want.cnt,
                                 status, start_frame, avail_count);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        req_type = bpa_pkg::REQ_QUERY;
        page_count = '0;
        byte_address = '0;
        out_ready = 1'b0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 0;
        hold_left = 0;
        quiet_cycles = 0;
        for (int r = 0; r < NREG; r++) begin
            rg_base[r]  = (r == 0) ? bpa_pkg::BASE0_RESET : 0;
            rg_pages[r] = (r == 0) ? bpa_pkg::PAGES0_RESET : 0;
        end
        for (int i = 0; i < bpa_pkg::PAGES; i++)
            page_free[i] = 1'b1;
        free_total = map_size();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_map();
        test_frame_edges();
        test_random_phase(0, 0, 1'b0);
        test_random_phase(63, 0, 1'b0);
        test_random_phase(0, 63, 1'b1);
        test_random_phase(37, 37, 1'b0);

        wait_drain();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/bpa_pkg.sv
rtl/bpa_regs.sv
rtl/bpa_mem.sv
rtl/bpa_ctrl.sv
rtl/bitmap_page_allocator_core.sv
bench/tb_top.sv
